[sv/rvaot_pkg.sv]
// rvaot_pkg: shared types and constants for the rva to file offset translator
// used by rvaot_cell, rvaot_chain and rva_to_file_offset_translator
`timescale 1ns / 1ps
`default_nettype none

package rvaot_pkg;

  localparam int AddrW  = 32;
  localparam int IdxW   = 7;
  localparam int CountW = 8;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgImageValid  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectionCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageSize   = 2'd2;

  // query token walking down the row of cells
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] offset;
  } token_t;

  // section entry write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] span;
    logic [AddrW-1:0] raw;
  } entry_wr_t;

  // result word, file_offset in the lowest bits
  typedef struct packed {
    logic             in_bounds;
    logic [IdxW-1:0]  hit_index;
    logic             section_hit;
    logic [AddrW-1:0] file_offset;
  } result_t;

endpackage

`default_nettype wire

[sv/rvaot_cell.sv]
// rvaot_cell: one section entry with its range compare and offset adjust
// depends on rvaot_pkg
`timescale 1ns / 1ps
`default_nettype none

module rvaot_cell import rvaot_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire entry_wr_t           wr_i,
  input  wire logic [AddrW-1:0]    addr_i,
  input  wire logic [CountW-1:0]   count_i,
  input  wire token_t              tok_i,
  output token_t                   tok_o
);

  localparam logic [IdxW-1:0] IdxBits = CELL_IDX[IdxW-1:0];

  logic [AddrW-1:0] start_q;
  logic [AddrW-1:0] end_q;
  logic [AddrW-1:0] delta_q;
  logic             wr_sel;
  logic             active;
  logic             match;
  token_t           tok_d;
  token_t           tok_q;

  assign wr_sel = wr_i.en && (32'(wr_i.idx) == 32'(CELL_IDX));
  assign active = 32'(count_i) > 32'(CELL_IDX);
  assign match  = tok_i.valid && !tok_i.hit && active &&
                  (addr_i >= start_q) && (addr_i < end_q);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit    = 1'b1;
      tok_d.idx    = IdxBits;
      tok_d.offset = addr_i + delta_q;
    end
  end

  // entry storage, end and raw minus start kept precomputed
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      start_q <= wr_i.start;
      end_q   <= wr_i.start + wr_i.span;
      delta_q <= wr_i.raw - wr_i.start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[sv/rvaot_chain.sv]
// rvaot_chain: row of section cells, one cell per table entry
// depends on rvaot_pkg and rvaot_cell
`timescale 1ns / 1ps
`default_nettype none

module rvaot_chain import rvaot_pkg::*; #(
  parameter int MAX_SECTIONS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire entry_wr_t         wr_i,
  input  wire logic [AddrW-1:0]  addr_i,
  input  wire logic [CountW-1:0] count_i,
  input  wire token_t            tok_i,
  output token_t                 tok_o
);

  token_t tok [MAX_SECTIONS+1];

  assign tok[0] = tok_i;

  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    rvaot_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr_i),
      .addr_i (addr_i),
      .count_i(count_i),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign tok_o = tok[MAX_SECTIONS];

endmodule

`default_nettype wire

[sv/rva_to_file_offset_translator.sv]
// rva_to_file_offset_translator: top level, config registers, query control,
// bounds check and output staging; depends on rvaot_pkg and rvaot_chain
//
// usage
// - s_axis carries one word per item; tuser selects the kind: 0 writes a
//   section entry, 1 asks for a translation. a write takes effect at the
//   accepting edge, gives no result; writes can follow every cycle while ready
// - a translation walks the row of section cells, one cell per cycle, the
//   first matching cell in row order wins; the query passes start_q, then
//   every cell register, and its result is registered into the output
//   register or spare slot; s_axis waits while that query is in the row
// - the cfg channel, always ready, writes image_valid, section_count and
//   image_size; write it only while no query is outstanding (not enforced)
// - m_axis has an output register plus one spare slot, so a new query is
//   accepted while a finished result still waits; while the spare slot is
//   full or a query is in the row, s_axis_tready is low
// - reset clears the config registers and all handshake state; section
//   entries are not cleared and must be written before they are used
`timescale 1ns / 1ps
`default_nettype none

module rva_to_file_offset_translator import rvaot_pkg::*; #(
  parameter int MAX_SECTIONS = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // entry_index, entry_start, entry_span, entry_raw, query_address,
  // query_length, zero pad
  input  wire logic [167:0]       s_axis_tdata,
  // mode
  input  wire logic               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // file_offset, section_hit, hit_index, in_bounds, zero pad
  output logic [47:0]             m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AddrW-1:0]   cfg_data_i
);

  logic              image_valid_q;
  logic [CountW-1:0] section_count_q;
  logic [AddrW-1:0]  image_size_q;

  logic              busy_q, busy_d;
  logic              start_q, start_d;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  len_q;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  result_t           out_q, out_d;
  result_t           skid_q, skid_d;

  logic              in_acc;
  logic              query_acc;
  logic              pop;
  entry_wr_t         wr;
  token_t            inject;
  token_t            tail;
  result_t           res;
  logic [AddrW-1:0]  off;
  logic [AddrW:0]    sum;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q && !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign query_acc     = in_acc && s_axis_tuser;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_valid_q   <= 1'b0;
      section_count_q <= '0;
      image_size_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageValid:   image_valid_q   <= cfg_data_i[0];
        CfgSectionCount: section_count_q <= cfg_data_i[CountW-1:0];
        CfgImageSize:    image_size_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wr.en    = in_acc && !s_axis_tuser;
  assign wr.idx   = s_axis_tdata[6:0];
  assign wr.start = s_axis_tdata[38:7];
  assign wr.span  = s_axis_tdata[70:39];
  assign wr.raw   = s_axis_tdata[102:71];

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      addr_q <= s_axis_tdata[134:103];
      len_q  <= s_axis_tdata[166:135];
    end
  end

  assign inject.valid  = start_q;
  assign inject.hit    = 1'b0;
  assign inject.idx    = '0;
  assign inject.offset = addr_q;

  rvaot_chain #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .addr_i (addr_q),
    .count_i(section_count_q),
    .tok_i  (inject),
    .tok_o  (tail)
  );

  // invalid image gating and bounds check
  always_comb begin
    off                 = image_valid_q ? tail.offset : '0;
    sum                 = {1'b0, off} + {1'b0, len_q};
    res.file_offset     = off;
    res.section_hit     = image_valid_q && tail.hit;
    res.hit_index       = res.section_hit ? tail.idx : '0;
    res.in_bounds       = (off < image_size_q) &&
                          ((len_q == '0) || (sum <= {1'b0, image_size_q}));
  end

  assign pop = out_valid_q && m_axis_tready;

  always_comb begin
    busy_d       = busy_q;
    start_d      = query_acc;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (query_acc) begin
      busy_d = 1'b1;
    end
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (tail.valid) begin
      busy_d = 1'b0;
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      start_q      <= start_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("spare slot holds a word while output register is empty");

  a_tail_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("query leaves the cell row with no query outstanding");

  a_tail_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> !skid_valid_q)
    else $error("query result arrives with no free output slot");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> busy_q && start_q)
    else $error("accepted query did not enter the cell row");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> busy_q && !skid_valid_q)
    else $error("query injected while not busy or spare slot full");

endmodule

`default_nettype wire
